// ===== design/bsd_pkg.sv =====
`default_nettype none

package bsd_pkg;

    // Default geometry
    localparam int WINDOW_DEF      = 50;
    localparam int MAX_SAMPLES_DEF = 1024;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int DEV_W    = 22;

    // Deviation limits and threshold reset value (0.17 g * 16384 * 50)
    localparam logic [DEV_W-1:0] DEV_MAX      = 22'h3F_FFFF;
    localparam logic [DEV_W-1:0] THRESH_RESET = 22'd139264;

    // Item kinds
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_CLOSE  = 2'd1;
    localparam logic [1:0] OP_FIX    = 2'd2;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [SAMPLE_W-1:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic             record_valid;
        logic [DEV_W-1:0] recorded_peak;
        logic             bump_pending;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_DEV,
        ST_UPD
    } t_state;

endpackage

`default_nettype wire

// ===== design/bsd_ram.sv =====
`default_nettype none

module bsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 50
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/bump_spike_detector.sv =====
// Bump spike detector for vertical acceleration.
// Input channel (i_in_valid / o_in_ready, i_in_data) carries one item per
// transfer: a sample, a sample that closes the averaging window, or a
// position fix. Output channel (o_out_valid / i_out_ready, o_out_data)
// returns exactly one result per input item, in order.
// Sample, fix and unused items finish in the accept cycle: the result is
// registered and visible in the next cycle. A window close runs a serial
// restoring divider (one quotient bit per cycle) followed by multiply,
// deviation and update steps; the update step waits while the result
// slot is full and not being drained. The block takes one item at a time;
// a new item enters only when the result slot is empty or being drained in
// the same cycle. If the receiver stalls, a finished result holds and the
// next item is held off until the slot frees. The threshold register is
// written through i_cfg_wr_en / i_cfg_wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Synchronous active-low reset clears all sums, the ring pointer, peak and
// pending flag and restores the threshold; ring entries are only read once
// the ring has been filled.
`default_nettype none

module bump_spike_detector
    import bsd_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out_data,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [DEV_W-1:0] i_cfg_wr_data
);

    // Derived widths
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RT_W   = SAMPLE_W + 1 + $clog2(WINDOW);
    localparam int D_W    = RT_W + 1;
    localparam int A_W    = (D_W > DEV_W) ? D_W : DEV_W;
    localparam int ITER_W = $clog2(SUM_W);

    localparam logic [CNT_W-1:0]      MAX_CNT  = CNT_W'(MAX_SAMPLES);
    localparam logic [PTR_W-1:0]      PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic [ITER_W-1:0]     ITER_TOP = ITER_W'(SUM_W - 1);
    localparam logic signed [D_W-1:0] WIN_S    = D_W'(WINDOW);

    // State
    t_state r_state, n_state;

    logic [DEV_W-1:0]        r_threshold;
    logic signed [SUM_W-1:0] r_window_sum;
    logic [CNT_W-1:0]        r_window_count;
    logic signed [RT_W-1:0]  r_ring_total;
    logic [PTR_W-1:0]        r_ring_ptr;
    logic                    r_ring_full;
    logic [DEV_W-1:0]        r_peak;
    logic                    r_pending;

    // Divider and datapath registers
    logic [SUM_W-1:0]           r_dvd;
    logic [CNT_W-1:0]           r_rem;
    logic                       r_neg;
    logic [ITER_W-1:0]          r_iter;
    logic signed [SAMPLE_W-1:0] r_avg;
    logic signed [D_W-1:0]      r_prod;
    logic [DEV_W-1:0]           r_dev;

    logic      r_out_valid;
    t_out_item r_out;

    // Sequencer strobes
    logic w_accept;
    logic w_out_free;
    logic w_upd_go;

    logic [SAMPLE_W-1:0] w_rd_data;

    // Output slot frees when empty or being drained
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in_data.opcode == OP_CLOSE) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (r_iter == '0) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_DEV;
            ST_DEV: n_state = ST_UPD;
            ST_UPD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_upd_go   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = w_out_free;
            ST_UPD:  w_upd_go   = w_out_free;
            default: begin
                o_in_ready = 1'b0;
                w_upd_go   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    // Divider step: shift in one dividend bit, subtract count if it fits
    logic [CNT_W:0] w_trial;
    logic [CNT_W:0] w_diff;
    logic           w_fits;

    assign w_trial = {r_rem, r_dvd[SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_window_count};
    assign w_fits  = w_trial >= {1'b0, r_window_count};

    // Signed quotient, truncated toward zero
    logic [SAMPLE_W:0] w_qmag;
    logic [SAMPLE_W:0] w_qsgn;

    assign w_qmag = r_dvd[SAMPLE_W:0];
    assign w_qsgn = r_neg ? (~w_qmag + 1'b1) : w_qmag;

    // Deviation against ring total
    logic signed [D_W-1:0] w_d;
    logic [D_W-1:0]        w_dabs;
    logic [A_W-1:0]        w_dext;
    logic [DEV_W-1:0]      w_dsat;
    logic signed [RT_W-1:0] w_old;
    logic signed [RT_W-1:0] w_avg_ext;

    assign w_d       = r_prod - D_W'(r_ring_total);
    assign w_dabs    = w_d[D_W-1] ? (~w_d + 1'b1) : w_d;
    assign w_dext    = A_W'(w_dabs);
    assign w_dsat    = (w_dext > A_W'(DEV_MAX)) ? DEV_MAX : w_dext[DEV_W-1:0];
    assign w_old     = r_ring_full ? RT_W'($signed(w_rd_data)) : '0;
    assign w_avg_ext = RT_W'(r_avg);

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_LOAD: begin
                r_neg  <= r_window_sum[SUM_W-1];
                r_dvd  <= r_window_sum[SUM_W-1] ? (~r_window_sum + 1'b1) : r_window_sum;
                r_rem  <= '0;
                r_iter <= ITER_TOP;
            end
            ST_DIV: begin
                r_dvd  <= {r_dvd[SUM_W-2:0], w_fits};
                r_rem  <= w_fits ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
                r_iter <= r_iter - 1'b1;
            end
            ST_MUL: begin
                r_avg  <= w_qsgn[SAMPLE_W-1:0];
                r_prod <= D_W'($signed(w_qsgn[SAMPLE_W-1:0])) * WIN_S;
            end
            ST_DEV: begin
                r_dev <= w_dsat;
            end
            default: begin
                r_dev <= r_dev;
            end
        endcase
    end

    // Window, ring and bump state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_sum   <= '0;
            r_window_count <= '0;
            r_ring_total   <= '0;
            r_ring_ptr     <= '0;
            r_ring_full    <= 1'b0;
            r_peak         <= '0;
            r_pending      <= 1'b0;
        end else begin
            // Sample add, saturating at MAX_SAMPLES
            if (w_accept && (i_in_data.opcode == OP_SAMPLE || i_in_data.opcode == OP_CLOSE)
                && r_window_count < MAX_CNT) begin
                r_window_sum   <= r_window_sum + SUM_W'(i_in_data.accel_z);
                r_window_count <= r_window_count + 1'b1;
            end
            // Fix item clears a pending bump
            if (w_accept && i_in_data.opcode == OP_FIX && r_pending) begin
                r_pending <= 1'b0;
                r_peak    <= '0;
            end
            // Ring total: drop oldest once full, add newest
            if (r_state == ST_DEV) begin
                r_ring_total <= r_ring_total - w_old + w_avg_ext;
            end
            // Finish window close
            if (w_upd_go) begin
                if (r_ring_full && r_dev > r_threshold && r_dev > r_peak) begin
                    r_peak    <= r_dev;
                    r_pending <= 1'b1;
                end
                if (r_ring_ptr == PTR_LAST) begin
                    r_ring_ptr  <= '0;
                    r_ring_full <= 1'b1;
                end else begin
                    r_ring_ptr <= r_ring_ptr + 1'b1;
                end
                r_window_sum   <= '0;
                r_window_count <= '0;
            end
        end
    end

    // Ring of window averages
    bsd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_upd_go),
        .i_wr_addr (r_ring_ptr),
        .i_wr_data (r_avg),
        .i_rd_addr (r_ring_ptr),
        .o_rd_data (w_rd_data)
    );

    // Result register
    logic w_bump_new;
    assign w_bump_new = r_ring_full && r_dev > r_threshold && r_dev > r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_accept && i_in_data.opcode != OP_CLOSE) || w_upd_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_go) begin
            r_out.record_valid  <= 1'b0;
            r_out.recorded_peak <= '0;
            r_out.bump_pending  <= r_pending || w_bump_new;
        end else if (w_accept) begin
            if (i_in_data.opcode == OP_FIX && r_pending) begin
                r_out.record_valid  <= 1'b1;
                r_out.recorded_peak <= r_peak;
                r_out.bump_pending  <= 1'b0;
            end else begin
                r_out.record_valid  <= 1'b0;
                r_out.recorded_peak <= '0;
                r_out.bump_pending  <= r_pending;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_div_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_window_count != '0))
        else $error("divide with zero sample count");

    a_pending_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending |-> (r_peak != '0)) and (!r_pending |-> (r_peak == '0)))
        else $error("peak and pending flag disagree");

    a_record_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.record_valid) |->
            (o_out_data.recorded_peak != '0 && !o_out_data.bump_pending))
        else $error("recorded bump left pending or empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_window_count <= MAX_CNT) && (r_ring_ptr <= PTR_LAST))
        else $error("sample count or ring pointer out of range");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("input taken while window close in progress");

endmodule

`default_nettype wire
